// ----- rtl/core/rsi_pkg.sv -----
// Shared types and constants for the ray/sphere intersection block.
// Holds the item structs, field widths and configuration register indexes.
// No dependencies.
package rsi_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned COORD_W       = 32;
  localparam int unsigned RAD_W         = 31;
  localparam int unsigned NORM_W        = 16;
  localparam int unsigned APB_ADDR_W    = 4;
  localparam int unsigned APB_DATA_W    = 32;

  localparam logic [RAD_W-1:0] RADIUS_RST = 31'd65536;

  typedef enum logic [1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_CENTER_Z = 2'd2,
    REG_RADIUS   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [COORD_W-1:0] dir_x;
    logic signed [COORD_W-1:0] dir_y;
    logic signed [COORD_W-1:0] dir_z;
  } ray_t;

  typedef struct packed {
    logic                     hit;
    logic [COORD_W-1:0]       distance_param;
    logic signed [NORM_W-1:0] normal_x;
    logic signed [NORM_W-1:0] normal_y;
    logic signed [NORM_W-1:0] normal_z;
  } result_t;

endpackage

// ----- rtl/core/ray_sphere_intersect.sv -----
// Ray/sphere intersection pipeline with its APB configuration registers.
// Depends on rsi_pkg for the item structs, widths and register indexes.
// Single module; all arithmetic is exact integer math.

// A ray item is taken in every cycle in which start is high; busy never rises,
// since the pipeline always moves and the receiver cannot stall it. Each ray
// produces exactly one result item, shown for one cycle with done_o high. Most
// of the pipeline is bit-per-stage units: 64 stages of square root for the
// discriminant, 32 stages of division for t and 14 stages of division for the
// normal, plus the product and sum stages around them. The sphere registers
// must be written only while no ray is in flight; the pipeline reads them live.
module ray_sphere_intersect #(
  parameter int unsigned FRAC_BITS = rsi_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  rsi_pkg::ray_t                       item_i,
  output logic                                done_o,
  output rsi_pkg::result_t                    result_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rsi_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [rsi_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [rsi_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready
);
  import rsi_pkg::*;

  // Widths of the internal quantities.
  localparam int unsigned LW    = COORD_W + 1;            // O - C
  localparam int unsigned AW    = 2 * COORD_W;            // A = D.D
  localparam int unsigned BW    = 2 * COORD_W + 3;        // b = D.L
  localparam int unsigned NW    = BW + 1;                 // root numerator
  localparam int unsigned XW    = 4 * COORD_W;            // squared terms
  localparam int unsigned RMW   = AW + 3;                 // sqrt remainder
  localparam int unsigned DRW   = AW + 1;                 // t divider remainder
  localparam int unsigned RSW   = RAD_W + FRAC_BITS;      // r * 2^F
  localparam int unsigned PW    = (((LW + FRAC_BITS) > (AW + 1)) ?
                                   (LW + FRAC_BITS) : (AW + 1)) + 1;
  localparam int unsigned QW    = NORM_W - 2;             // normal quotient bits
  localparam int unsigned SQ_N  = AW;
  localparam int unsigned DV_N  = COORD_W;
  localparam int unsigned NM_N  = QW;
  localparam int unsigned LAT   = 7 + SQ_N + 2 + DV_N + 2 + NM_N + 1;
  localparam int unsigned CMPW  = AW + COORD_W;
  localparam logic [QW:0] NORM_ONE = {1'b1, {QW{1'b0}}};

  typedef struct packed {
    logic                      miss;
    logic [AW-1:0]             a;
    logic [BW-1:0]             b;
    logic [2:0][COORD_W-1:0]   d;
    logic [2:0][LW-1:0]        l;
  } ctx_t;

  typedef struct packed {
    ctx_t           c;
    logic [RMW-1:0] rem;
    logic [AW-1:0]  root;
    logic [XW-1:0]  xs;
  } sq_t;

  typedef struct packed {
    ctx_t               c;
    logic               sat;
    logic [DRW-1:0]     rem;
    logic [COORD_W-1:0] nl;
    logic [COORD_W-1:0] q;
  } dv_t;

  typedef struct packed {
    logic                 miss;
    logic [COORD_W-1:0]   t;
    logic [2:0]           neg;
    logic [2:0]           clamp;
    logic [2:0][RSW:0]    rem;
    logic [2:0][QW-1:0]   q;
  } nm_t;

  // ---------------------------------------------------------------------------
  // Configuration registers. A write lands in the access phase; reads are
  // answered at once, so pready stays high.
  // ---------------------------------------------------------------------------
  logic [2:0][COORD_W-1:0] center_q;
  logic [RAD_W-1:0]        radius_q;
  reg_idx_e                reg_idx;

  assign reg_idx = reg_idx_e'(paddr[APB_ADDR_W-1:2]);
  assign pready  = 1'b1;
  assign busy    = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= '0;
      radius_q <= RADIUS_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_CENTER_X: center_q[0] <= pwdata[COORD_W-1:0];
        REG_CENTER_Y: center_q[1] <= pwdata[COORD_W-1:0];
        REG_CENTER_Z: center_q[2] <= pwdata[COORD_W-1:0];
        REG_RADIUS:   radius_q    <= pwdata[RAD_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CENTER_X: prdata = APB_DATA_W'(center_q[0]);
      REG_CENTER_Y: prdata = APB_DATA_W'(center_q[1]);
      REG_CENTER_Z: prdata = APB_DATA_W'(center_q[2]);
      REG_RADIUS:   prdata = APB_DATA_W'(radius_q);
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Valid bits travel down a shift line next to the payload stages. Nothing
  // ever stalls, so one bit per stage is all the control there is.
  // ---------------------------------------------------------------------------
  logic [LAT-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], start && !busy};
    end
  end

  assign done_o = vld_q[LAT-1];

  // ---------------------------------------------------------------------------
  // Stage 0: capture the ray and form L = O - C.
  // ---------------------------------------------------------------------------
  logic [2:0][COORD_W-1:0] d0_q;
  logic [2:0][LW-1:0]      l0_q;

  always_ff @(posedge clk_i) begin
    d0_q[0] <= item_i.dir_x;
    d0_q[1] <= item_i.dir_y;
    d0_q[2] <= item_i.dir_z;
    l0_q[0] <= LW'(item_i.origin_x) - LW'($signed(center_q[0]));
    l0_q[1] <= LW'(item_i.origin_y) - LW'($signed(center_q[1]));
    l0_q[2] <= LW'(item_i.origin_z) - LW'($signed(center_q[2]));
  end

  // ---------------------------------------------------------------------------
  // Stage 1: the 32x32 squares of D and the 32x33 products of D and L. The
  // cross product D x L is kept as two terms per component; r^2 is formed here too.
  // ---------------------------------------------------------------------------
  logic signed [AW-1:0]     sq1_d [3];
  logic signed [AW:0]       cp1_d [3];
  logic signed [AW:0]       cn1_d [3];
  logic signed [AW:0]       dl1_d [3];
  logic [2*RAD_W-1:0]       rr1_d;
  logic signed [AW-1:0]     sq1_q [3];
  logic signed [AW:0]       cp1_q [3];
  logic signed [AW:0]       cn1_q [3];
  logic signed [AW:0]       dl1_q [3];
  logic [2*RAD_W-1:0]       rr1_q;
  logic [2:0][COORD_W-1:0]  d1_q;
  logic [2:0][LW-1:0]       l1_q;

  always_comb begin
    int j;
    int k;
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      k = (i + 2) % 3;
      sq1_d[i] = $signed(d0_q[i]) * $signed(d0_q[i]);
      cp1_d[i] = $signed(d0_q[j]) * $signed(l0_q[k]);
      cn1_d[i] = $signed(d0_q[k]) * $signed(l0_q[j]);
      dl1_d[i] = $signed(d0_q[i]) * $signed(l0_q[i]);
    end
    rr1_d = radius_q * radius_q;
  end

  always_ff @(posedge clk_i) begin
    sq1_q <= sq1_d;
    cp1_q <= cp1_d;
    cn1_q <= cn1_d;
    dl1_q <= dl1_d;
    rr1_q <= rr1_d;
    d1_q  <= d0_q;
    l1_q  <= l0_q;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: A, b and the magnitudes of the cross product components.
  // A zero direction or a zero radius is a miss from here on.
  // ---------------------------------------------------------------------------
  ctx_t                c2_d, c2_q;
  logic [2:0][AW-1:0]  m2_d, m2_q;
  logic [2*RAD_W-1:0]  rr2_q;

  always_comb begin
    logic signed [AW+1:0] cr;
    c2_d.a = AW'(sq1_q[0]) + AW'(sq1_q[1]) + AW'(sq1_q[2]);
    c2_d.b = BW'(dl1_q[0]) + BW'(dl1_q[1]) + BW'(dl1_q[2]);
    c2_d.d = d1_q;
    c2_d.l = l1_q;
    c2_d.miss = (c2_d.a == '0) || (radius_q == '0);
    for (int i = 0; i < 3; i++) begin
      cr = cp1_q[i] - cn1_q[i];
      m2_d[i] = cr[AW+1] ? AW'(-cr) : AW'(cr);
    end
  end

  always_ff @(posedge clk_i) begin
    c2_q  <= c2_d;
    m2_q  <= m2_d;
    rr2_q <= rr1_q;
  end

  // ---------------------------------------------------------------------------
  // Stage 3: 32x32 partial products of |D x L|^2 and of A * r^2.
  // ---------------------------------------------------------------------------
  localparam int unsigned HW = AW / 2;

  ctx_t                c3_q;
  logic [2:0][AW-1:0]  pll3_d, plh3_d, phh3_d, pll3_q, plh3_q, phh3_q;
  logic [AW-1:0]       yll3_d, ylh3_d, yhl3_d, yhh3_d, yll3_q, ylh3_q, yhl3_q, yhh3_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pll3_d[i] = AW'(m2_q[i][HW-1:0]) * AW'(m2_q[i][HW-1:0]);
      plh3_d[i] = AW'(m2_q[i][HW-1:0]) * AW'(m2_q[i][AW-1:HW]);
      phh3_d[i] = AW'(m2_q[i][AW-1:HW]) * AW'(m2_q[i][AW-1:HW]);
    end
    yll3_d = AW'(c2_q.a[HW-1:0])  * AW'(rr2_q[HW-1:0]);
    ylh3_d = AW'(c2_q.a[HW-1:0])  * AW'(rr2_q[2*RAD_W-1:HW]);
    yhl3_d = AW'(c2_q.a[AW-1:HW]) * AW'(rr2_q[HW-1:0]);
    yhh3_d = AW'(c2_q.a[AW-1:HW]) * AW'(rr2_q[2*RAD_W-1:HW]);
  end

  always_ff @(posedge clk_i) begin
    c3_q   <= c2_q;
    pll3_q <= pll3_d;
    plh3_q <= plh3_d;
    phh3_q <= phh3_d;
    yll3_q <= yll3_d;
    ylh3_q <= ylh3_d;
    yhl3_q <= yhl3_d;
    yhh3_q <= yhh3_d;
  end

  // ---------------------------------------------------------------------------
  // Stage 4: assemble the three squares and y = A * r^2.
  // ---------------------------------------------------------------------------
  ctx_t                c4_q;
  logic [2:0][XW-1:0]  sqm4_d, sqm4_q;
  logic [XW-1:0]       y4_d, y4_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sqm4_d[i] = (XW'(phh3_q[i]) << AW) + (XW'(plh3_q[i]) << (HW + 1)) +
                  XW'(pll3_q[i]);
    end
    y4_d = (XW'(yhh3_q) << AW) + ((XW'(ylh3_q) + XW'(yhl3_q)) << HW) + XW'(yll3_q);
  end

  always_ff @(posedge clk_i) begin
    c4_q   <= c3_q;
    sqm4_q <= sqm4_d;
    y4_q   <= y4_d;
  end

  // ---------------------------------------------------------------------------
  // Stage 5: x = |D x L|^2, kept two bits wider than the squares so it cannot wrap.
  // ---------------------------------------------------------------------------
  ctx_t            c5_q;
  logic [XW+1:0]   x5_q;
  logic [XW-1:0]   y5_q;

  always_ff @(posedge clk_i) begin
    c5_q <= c4_q;
    x5_q <= (XW+2)'(sqm4_q[0]) + (XW+2)'(sqm4_q[1]) + (XW+2)'(sqm4_q[2]);
    y5_q <= y4_q;
  end

  // ---------------------------------------------------------------------------
  // Stage 6: discriminant disc = A*r^2 - |D x L|^2; negative means a miss.
  // The register is the head of the square root line.
  // ---------------------------------------------------------------------------
  sq_t sq_q [SQ_N+1];
  sq_t sq0_d;

  always_comb begin
    sq0_d.c      = c5_q;
    sq0_d.c.miss = c5_q.miss || (x5_q > (XW+2)'(y5_q));
    sq0_d.rem    = '0;
    sq0_d.root   = '0;
    sq0_d.xs     = y5_q - x5_q[XW-1:0];
  end

  always_ff @(posedge clk_i) begin
    sq_q[0] <= sq0_d;
  end

  // Restoring square root, one result bit per stage: the remainder takes the
  // next two radicand bits and the trial value 4*root + 1 is subtracted if it
  // fits.
  for (genvar k = 1; k <= SQ_N; k++) begin : g_sqrt
    sq_t            nx;
    logic [RMW-1:0] rs;
    logic [RMW-1:0] tr;

    always_comb begin
      nx    = sq_q[k-1];
      rs    = {sq_q[k-1].rem[RMW-3:0], sq_q[k-1].xs[XW-1:XW-2]};
      tr    = {1'b0, sq_q[k-1].root, 2'b01};
      nx.xs = sq_q[k-1].xs << 2;
      if (rs >= tr) begin
        nx.rem  = rs - tr;
        nx.root = {sq_q[k-1].root[AW-2:0], 1'b1};
      end else begin
        nx.rem  = rs;
        nx.root = {sq_q[k-1].root[AW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      sq_q[k] <= nx;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 7: pick the nearer root whose numerator is positive.
  // ---------------------------------------------------------------------------
  ctx_t           c7_d, c7_q;
  logic [NW-1:0]  n7_d, n7_q;

  always_comb begin
    logic signed [NW-1:0] nb;
    logic signed [NW-1:0] sx;
    logic signed [NW-1:0] n1;
    logic signed [NW-1:0] n2;
    nb   = -NW'($signed(sq_q[SQ_N].c.b));
    sx   = $signed(NW'(sq_q[SQ_N].root));
    n1   = nb - sx;
    n2   = nb + sx;
    c7_d = sq_q[SQ_N].c;
    if (n1 > 0) begin
      n7_d = n1;
    end else begin
      n7_d = n2;
      if (n2 <= 0) begin
        c7_d.miss = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    c7_q <= c7_d;
    n7_q <= n7_d;
  end

  // ---------------------------------------------------------------------------
  // Stage 8: t = floor(n * 2^F / A). If the quotient cannot fit 32 bits,
  // t saturates; otherwise the part of n*2^F above bit 31 is already below A
  // and seeds the remainder of a 32-step divider.
  // ---------------------------------------------------------------------------
  dv_t dv_q [DV_N+1];
  dv_t dv0_d;

  always_comb begin
    logic [NW+FRAC_BITS-1:0] nsh;
    nsh       = {n7_q, {FRAC_BITS{1'b0}}};
    dv0_d.c   = c7_q;
    dv0_d.sat = CMPW'(n7_q) >= (CMPW'(c7_q.a) << (COORD_W - FRAC_BITS));
    dv0_d.rem = DRW'(nsh[NW+FRAC_BITS-1:COORD_W]);
    dv0_d.nl  = nsh[COORD_W-1:0];
    dv0_d.q   = '0;
  end

  always_ff @(posedge clk_i) begin
    dv_q[0] <= dv0_d;
  end

  for (genvar k = 1; k <= DV_N; k++) begin : g_tdiv
    dv_t            nx;
    logic [DRW-1:0] rs;

    always_comb begin
      nx    = dv_q[k-1];
      rs    = {dv_q[k-1].rem[DRW-2:0], dv_q[k-1].nl[COORD_W-1]};
      nx.nl = dv_q[k-1].nl << 1;
      if (rs >= DRW'(dv_q[k-1].c.a)) begin
        nx.rem = rs - DRW'(dv_q[k-1].c.a);
        nx.q   = {dv_q[k-1].q[COORD_W-2:0], 1'b1};
      end else begin
        nx.rem = rs;
        nx.q   = {dv_q[k-1].q[COORD_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      dv_q[k] <= nx;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage T: t * D and L * 2^F for the hit point relative to the center.
  // ---------------------------------------------------------------------------
  logic                          mt_q;
  logic [COORD_W-1:0]            tt_d, tt_q;
  logic signed [AW:0]            td_d [3];
  logic signed [AW:0]            td_q [3];
  logic signed [LW+FRAC_BITS-1:0] ls_q [3];

  always_comb begin
    tt_d = dv_q[DV_N].sat ? '1 : dv_q[DV_N].q;
    for (int i = 0; i < 3; i++) begin
      td_d[i] = $signed({1'b0, tt_d}) * $signed(dv_q[DV_N].c.d[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    mt_q <= dv_q[DV_N].c.miss;
    tt_q <= tt_d;
    td_q <= td_d;
    for (int i = 0; i < 3; i++) begin
      ls_q[i] <= {dv_q[DV_N].c.l[i], {FRAC_BITS{1'b0}}};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage P: P = L*2^F + t*D and its magnitude. A magnitude at or above
  // r*2^F clamps the component to one; otherwise it heads a 14-step divider.
  // ---------------------------------------------------------------------------
  nm_t            nm_q [NM_N+1];
  nm_t            nm0_d;
  logic [RSW-1:0] rsc;

  assign rsc = {radius_q, {FRAC_BITS{1'b0}}};

  always_comb begin
    logic signed [PW-1:0] p;
    logic [PW-1:0]        ap;
    nm0_d.miss = mt_q;
    nm0_d.t    = tt_q;
    nm0_d.q    = '0;
    for (int i = 0; i < 3; i++) begin
      p = PW'(ls_q[i]) + PW'(td_q[i]);
      ap = p[PW-1] ? PW'(-p) : PW'(p);
      nm0_d.neg[i]   = p[PW-1];
      nm0_d.clamp[i] = ap >= PW'(rsc);
      nm0_d.rem[i]   = (RSW+1)'(ap);
    end
  end

  always_ff @(posedge clk_i) begin
    nm_q[0] <= nm0_d;
  end

  for (genvar k = 1; k <= NM_N; k++) begin : g_ndiv
    nm_t          nx;
    logic [RSW:0] rs;

    always_comb begin
      nx = nm_q[k-1];
      rs = '0;
      for (int i = 0; i < 3; i++) begin
        rs = {nm_q[k-1].rem[i][RSW-1:0], 1'b0};
        if (rs >= (RSW+1)'(rsc)) begin
          nx.rem[i] = rs - (RSW+1)'(rsc);
          nx.q[i]   = {nm_q[k-1].q[i][QW-2:0], 1'b1};
        end else begin
          nx.rem[i] = rs;
          nx.q[i]   = {nm_q[k-1].q[i][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      nm_q[k] <= nx;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: signs restored, a miss forces every field to zero.
  // ---------------------------------------------------------------------------
  result_t                 res_d, res_q;
  logic [2:0][NORM_W-1:0]  nv;

  always_comb begin
    logic [QW:0] v;
    for (int i = 0; i < 3; i++) begin
      v = nm_q[NM_N].clamp[i] ? NORM_ONE : {1'b0, nm_q[NM_N].q[i]};
      nv[i] = nm_q[NM_N].neg[i] ? -NORM_W'(v) : NORM_W'(v);
    end
    if (nm_q[NM_N].miss) begin
      res_d = '0;
    end else begin
      res_d.hit            = 1'b1;
      res_d.distance_param = nm_q[NM_N].t;
      res_d.normal_x       = nv[0];
      res_d.normal_y       = nv[1];
      res_d.normal_z       = nv[2];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_o = res_q;

endmodule
